[rtl/smn_pkg.sv]
// ----------------------------------------------------------------------------
// smn_pkg
// shared types and constants of the softsign neuron multiply-accumulate block
// ----------------------------------------------------------------------------
package smn_pkg;

  localparam int unsigned AccWidthDef = 48;
  localparam int unsigned FracBitsDef = 12;
  localparam int unsigned DataWidth   = 16;
  localparam int unsigned ProdWidth   = 2 * DataWidth;
  localparam int unsigned QuotBits    = 15;
  localparam int unsigned CntWidth    = $clog2(QuotBits);

  typedef struct packed {
    logic signed [DataWidth-1:0] weight_value;
    logic signed [DataWidth-1:0] input_activation;
    logic                        last_term;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] neuron_output;
    logic                        sum_saturated;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StAcc   = 6'b000010,
    StBias  = 6'b000100,
    StStart = 6'b001000,
    StDiv   = 6'b010000,
    StSpare = 6'b100000
  } state_e;

endpackage

[rtl/softsign_neuron_mac_top.sv]
// ----------------------------------------------------------------------------
// softsign_neuron_mac_top
// single neuron: saturating multiply-accumulate, bias and softsign activation
// ----------------------------------------------------------------------------
//  port group      direction  handshake                 payload
//  in_*            in         in_valid_i / in_ready_o    smn_pkg::in_item_t
//  out_*           out        out_valid_o / out_ready_i  smn_pkg::out_item_t
//  bias_value_*    in         bias_value_we_i            16-bit signed bias
//
//  an item that is not last goes through multiply, then saturating add
//  a last item goes through multiply, add, bias add, divider start and
//  15 quotient bits from the restoring divider, then the result write
//  the result register holds one item; a new item is taken while it waits,
//  but a further result stalls until it has been taken
//  reset clears the accumulator, saturation flag and bias
// ----------------------------------------------------------------------------
module softsign_neuron_mac_top #(
  parameter int unsigned ACC_WIDTH = smn_pkg::AccWidthDef,
  parameter int unsigned FRAC_BITS = smn_pkg::FracBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  smn_pkg::in_item_t                    in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output smn_pkg::out_item_t                   out_item_o,
  input  logic                                 bias_value_we_i,
  input  logic signed [smn_pkg::DataWidth-1:0] bias_value_i
);

  smn_pkg::state_e state_q, state_d;

  logic signed [ACC_WIDTH-1:0]          sum_q, sum_d;
  logic                                 sat_q, sat_d;
  logic signed [smn_pkg::DataWidth-1:0] bias_q;
  logic signed [smn_pkg::ProdWidth-1:0] prod_q, prod_d;
  logic                                 last_q, last_d;
  logic                                 out_valid_q, out_valid_d;
  smn_pkg::out_item_t                   out_item_q, out_item_d;

  logic signed [ACC_WIDTH-1:0] addend;
  logic        [ACC_WIDTH:0]   wide;
  logic                        ovf;
  logic signed [ACC_WIDTH-1:0] sat_res;
  logic                        div_start;
  smn_pkg::div_stat_t          div_stat;
  logic signed [smn_pkg::DataWidth-1:0] div_q;
  logic                        slot_free;

  // shared saturating adder for products and bias
  assign addend  = (state_q == smn_pkg::StBias)
                 ? (ACC_WIDTH'(bias_q) <<< FRAC_BITS)
                 : ACC_WIDTH'(prod_q);
  assign wide    = {sum_q[ACC_WIDTH-1], sum_q} + {addend[ACC_WIDTH-1], addend};
  assign ovf     = wide[ACC_WIDTH] != wide[ACC_WIDTH-1];
  assign sat_res = ovf ? (wide[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                          : {1'b0, {(ACC_WIDTH-1){1'b1}}})
                       : wide[ACC_WIDTH-1:0];

  assign slot_free  = !out_valid_q || out_ready_i;
  assign div_start  = (state_q == smn_pkg::StStart);
  assign in_ready_o = (state_q == smn_pkg::StIdle);

  smn_divider #(
    .ACC_WIDTH (ACC_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (sum_q),
    .stat_o  (div_stat),
    .q_o     (div_q)
  );

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    prod_d      = prod_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    unique case (state_q)
      smn_pkg::StIdle: begin
        if (in_valid_i) begin
          prod_d  = in_item_i.weight_value * in_item_i.input_activation;
          last_d  = in_item_i.last_term;
          state_d = smn_pkg::StAcc;
        end
      end
      smn_pkg::StAcc: begin
        sum_d   = sat_res;
        sat_d   = sat_q | ovf;
        state_d = last_q ? smn_pkg::StBias : smn_pkg::StIdle;
      end
      smn_pkg::StBias: begin
        sum_d   = sat_res;
        sat_d   = sat_q | ovf;
        state_d = smn_pkg::StStart;
      end
      smn_pkg::StStart: begin
        state_d = smn_pkg::StDiv;
      end
      smn_pkg::StDiv: begin
        if (div_stat.done && !div_stat.busy && slot_free) begin
          out_valid_d              = 1'b1;
          out_item_d.neuron_output = div_q;
          out_item_d.sum_saturated = sat_q;
          sum_d                    = '0;
          sat_d                    = 1'b0;
          state_d                  = smn_pkg::StIdle;
        end
      end
      default: begin
        state_d = smn_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smn_pkg::StIdle;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      bias_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      if (bias_value_we_i) begin
        bias_q <= bias_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    last_q     <= last_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[rtl/smn_divider.sv]
// ----------------------------------------------------------------------------
// smn_divider
// sequential restoring divider for softsign: a / (2^(2*frac) + |a|) in q1.15
// ----------------------------------------------------------------------------
module smn_divider #(
  parameter int unsigned ACC_WIDTH = smn_pkg::AccWidthDef,
  parameter int unsigned FRAC_BITS = smn_pkg::FracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [ACC_WIDTH-1:0]         a_i,
  output smn_pkg::div_stat_t                  stat_o,
  output logic signed [smn_pkg::DataWidth-1:0] q_o
);

  localparam int unsigned RW = ACC_WIDTH + 1;

  logic [RW-1:0]                     r_q, r_d, d_q, d_d;
  logic [smn_pkg::QuotBits-1:0]      q_q, q_d;
  logic [smn_pkg::CntWidth-1:0]      cnt_q, cnt_d;
  logic                              neg_q, neg_d;
  logic                              busy_q, busy_d;
  logic                              done_q, done_d;

  logic [RW-1:0] a_ext;
  logic [RW-1:0] mag;
  logic [RW:0]   r2;
  logic [RW:0]   diff;
  logic          ge;

  assign a_ext = {a_i[ACC_WIDTH-1], a_i};
  assign mag   = a_i[ACC_WIDTH-1] ? (~a_ext + RW'(1)) : a_ext;
  assign r2    = {r_q, 1'b0};
  assign diff  = r2 - {1'b0, d_q};
  assign ge    = (r2 >= {1'b0, d_q});

  always_comb begin
    r_d    = r_q;
    d_d    = d_q;
    q_d    = q_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      r_d    = mag;
      d_d    = mag + (RW'(1) << (2 * FRAC_BITS));
      q_d    = '0;
      cnt_d  = '0;
      neg_d  = a_i[ACC_WIDTH-1];
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      r_d   = ge ? diff[RW-1:0] : r2[RW-1:0];
      q_d   = {q_q[smn_pkg::QuotBits-2:0], ge};
      cnt_d = cnt_q + smn_pkg::CntWidth'(1);
      if (cnt_q == smn_pkg::CntWidth'(smn_pkg::QuotBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    d_q   <= d_d;
    q_q   <= q_d;
    neg_q <= neg_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign q_o = neg_q ? smn_pkg::DataWidth'(~{1'b0, q_q} + smn_pkg::DataWidth'(1))
                     : smn_pkg::DataWidth'({1'b0, q_q});

endmodule

[tb/sv/tb_softsign_neuron_mac_top.sv]
// ----------------------------------------------------------------------------
// tb_softsign_neuron_mac_top
// self-checking bench for the softsign neuron: weight and activation pairs go
// in, each vector's softsign result is predicted with the bias and the
// clamping accumulator and compared field by field, under varying idle and
// stall pressure on both channels
// ----------------------------------------------------------------------------
module tb_softsign_neuron_mac_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SumMax   = (64'sd1 <<< (smn_pkg::AccWidthDef - 1)) - 64'sd1;
  localparam longint SumMin   = -SumMax - 64'sd1;
  localparam int     HoldOff  = 30;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  smn_pkg::in_item_t  in_item_i       = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  smn_pkg::out_item_t out_item_o;
  logic               bias_value_we_i = 1'b0;
  logic signed [smn_pkg::DataWidth-1:0] bias_value_i = '0;

  longint                               model_sum;
  bit                                   model_clamped;
  logic signed [smn_pkg::DataWidth-1:0] model_bias;

  smn_pkg::out_item_t pending_activations[$];
  int                 mismatch_count     = 0;
  int                 sender_idle_pct    = 0;
  int                 receiver_stall_pct = 0;

  softsign_neuron_mac_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_item_i       (in_item_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_item_o      (out_item_o),
    .bias_value_we_i (bias_value_we_i),
    .bias_value_i    (bias_value_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint clamped_add(input longint s, input longint p);
    if (p > 0 && s > SumMax - p) begin
      model_clamped = 1'b1;
      return SumMax;
    end
    if (p < 0 && s < SumMin - p) begin
      model_clamped = 1'b1;
      return SumMin;
    end
    return s + p;
  endfunction

  function automatic void predict_neuron(input smn_pkg::in_item_t term, output bit fired,
                                         output smn_pkg::out_item_t res);
    longint      prod;
    longint      mag;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    logic [15:0] q16;
    prod = longint'($signed(term.weight_value)) * longint'($signed(term.input_activation));
    model_sum = clamped_add(model_sum, prod);
    fired = term.last_term;
    res = '0;
    if (term.last_term) begin
      model_sum = clamped_add(model_sum,
                              longint'(model_bias) * (64'sd1 <<< smn_pkg::FracBitsDef));
      mag = (model_sum < 0) ? -model_sum : model_sum;
      num = 64'(mag) << smn_pkg::QuotBits;
      den = 64'(mag) + (64'd1 << (2 * smn_pkg::FracBitsDef));
      quo = num / den;
      q16 = quo[15:0];
      if (model_sum < 0) q16 = -q16;
      res.neuron_output = q16;
      res.sum_saturated = model_clamped;
      model_sum = 0;
      model_clamped = 1'b0;
    end
  endfunction

  function automatic smn_pkg::in_item_t make_term(input logic signed [15:0] w,
                                                  input logic signed [15:0] x,
                                                  input logic l);
    smn_pkg::in_item_t t;
    t.weight_value     = w;
    t.input_activation = x;
    t.last_term        = l;
    return t;
  endfunction

  function automatic logic signed [15:0] rand_q412();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'($urandom_range(0, 8191)) - 16'sh1000;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin : result_monitor
    smn_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_activations.size() == 0) begin
        $error("unexpected item: neuron_output %0d sum_saturated %0b",
               out_item_o.neuron_output, out_item_o.sum_saturated);
        mismatch_count++;
      end else begin
        want = pending_activations.pop_front();
        if (out_item_o.neuron_output !== want.neuron_output) begin
          $error("neuron_output: expected %0d, got %0d",
                 want.neuron_output, out_item_o.neuron_output);
          mismatch_count++;
        end
        if (out_item_o.sum_saturated !== want.sum_saturated) begin
          $error("sum_saturated: expected %0b, got %0b",
                 want.sum_saturated, out_item_o.sum_saturated);
          mismatch_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  task automatic push_term(input smn_pkg::in_item_t term);
    bit                 fired;
    smn_pkg::out_item_t res;
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= term;
    do @(posedge clk_i); while (!in_ready_o);
    predict_neuron(term, fired, res);
    if (fired) pending_activations = {pending_activations, res};
  endtask

  task automatic await_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_activations.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle_block();
    await_results();
    repeat (HoldOff) @(posedge clk_i);
  endtask

  task automatic write_bias(input logic signed [15:0] v);
    bias_value_we_i <= 1'b1;
    bias_value_i    <= v;
    @(posedge clk_i);
    bias_value_we_i <= 1'b0;
    model_bias = v;
  endtask

  task automatic test_field_extremes();
    push_term(make_term(16'sh7fff, 16'sh7fff, 1'b1));
    push_term(make_term(16'sh8000, 16'sh8000, 1'b1));
    push_term(make_term(16'sh8000, 16'sh7fff, 1'b1));
    push_term(make_term(16'sh7fff, 16'sh8000, 1'b1));
    push_term(make_term(16'sh0000, 16'sh0000, 1'b1));
    push_term(make_term(16'sh0001, 16'sh0001, 1'b1));
    push_term(make_term(16'shffff, 16'sh0001, 1'b1));
    push_term(make_term(16'sh0000, 16'sh8000, 1'b1));
    push_term(make_term(16'sh7fff, 16'sh7fff, 1'b0));
    push_term(make_term(16'sh8000, 16'sh8000, 1'b0));
    push_term(make_term(16'sh5a5a, 16'sha5a5, 1'b0));
    push_term(make_term(16'sh1000, 16'shf000, 1'b1));
  endtask

  task automatic test_bias_extremes();
    settle_block();
    write_bias(16'sh7fff);
    push_term(make_term(16'sh0000, 16'sh0000, 1'b1));
    push_term(make_term(16'sh1000, 16'sh1000, 1'b1));
    settle_block();
    write_bias(16'sh8000);
    push_term(make_term(16'sh0000, 16'sh0000, 1'b1));
    push_term(make_term(16'shf000, 16'sh1000, 1'b1));
    push_term(make_term(16'sh8000, 16'sh8000, 1'b1));
  endtask

  task automatic test_random_vectors(input int idle_pct, input int stall_pct,
                                     input logic signed [15:0] bias, input int n_items);
    int sent;
    int len;
    settle_block();
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    write_bias(bias);
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        push_term(make_term(rand_q412(), rand_q412(), i == len - 1));
      end
      sent += len;
      if ($urandom_range(0, 29) == 0) await_results();
    end
  endtask

  initial begin
    model_sum     = 0;
    model_clamped = 1'b0;
    model_bias    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_bias_extremes();
    test_random_vectors(0, 0, 16'($urandom), 260);
    test_random_vectors(74, 0, 16'sh8000, 260);
    test_random_vectors(0, 74, 16'sh7fff, 260);
    test_random_vectors(22, 22, 16'($urandom), 270);
    settle_block();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
